FILE: sv/mvc_pkg.sv
package mvc_pkg;

    // Cache geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Field widths
    localparam int FUNC_W  = 2;
    localparam int KEY_W   = 64;
    localparam int VAL_W   = 64;
    localparam int CFG_W   = 5;
    localparam int TALLY_W = 32;
    localparam int LINE_W  = KEY_W + VAL_W;
    localparam int CMP_W   = (CFG_W > CNT_W) ? CFG_W : CNT_W;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOOKUP = 2'd0,
        FUNC_FILL   = 2'd1,
        FUNC_INVAL  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN
    } state_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_HIT,
        RES_MISS
    } res_t;

    // Controller to datapath
    typedef struct packed {
        logic             load;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             cmp_vld;
        logic [IDX_W-1:0] cmp_idx;
        logic             fill;
        logic             inval;
        logic             finish;
        res_t             res;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CNT_W-1:0]  n;
        logic              match;
    } status_t;

endpackage

FILE: sv/memo_value_cache_fifo_top.sv
// Channel   Handshake        Payload
// --------  ---------------  ------------------------------------------
// command   start / busy     func, key, fill_value
// result    done (1 cycle)   hit, value_out, hit_count, miss_count
// config    cfg_we           entries_in_use
//
// A lookup scans at most the entries in use, from entry zero, and stops on the
// first hit: the single read port of the key/value store yields one entry per
// cycle. busy is low in the cycle done is shown, so the next item can be taken
// then. The receiver cannot stall. Reset clears valid bits, pointer, counters
// and the entry count at once.
module memo_value_cache_fifo_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mvc_pkg::FUNC_W-1:0]    func,
    input  logic [mvc_pkg::KEY_W-1:0]     key,
    input  logic [mvc_pkg::VAL_W-1:0]     fill_value,
    input  logic                          cfg_we,
    input  logic [mvc_pkg::CFG_W-1:0]     entries_in_use,
    output logic                          done,
    output logic                          hit,
    output logic [mvc_pkg::VAL_W-1:0]     value_out,
    output logic [mvc_pkg::TALLY_W-1:0]   hit_count,
    output logic [mvc_pkg::TALLY_W-1:0]   miss_count
);

    import mvc_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequence the operation
    mvc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Store, compare and tally
    mvc_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .func           (func),
        .key            (key),
        .fill_value     (fill_value),
        .cfg_we         (cfg_we),
        .entries_in_use (entries_in_use),
        .done           (done),
        .hit            (hit),
        .value_out      (value_out),
        .hit_count      (hit_count),
        .miss_count     (miss_count)
    );

endmodule

FILE: sv/mvc_ram.sv
module mvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/mvc_ctrl.sv
module mvc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  mvc_pkg::status_t status,
    output mvc_pkg::cmd_t    cmd,
    output logic             busy
);

    import mvc_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic             pend_last;

    // Hold state and scan position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_idx_reg <= '0;
            pend_vld_reg <= 1'b0;
            pend_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            pend_vld_reg <= pend_vld_next;
            pend_idx_reg <= pend_idx_next;
        end
    end

    assign pend_last = (CNT_W'(pend_idx_reg) + CNT_W'(1)) >= status.n;

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        pend_vld_next = 1'b0;
        pend_idx_next = pend_idx_reg;
        cmd           = '0;
        cmd.res       = RES_NONE;
        cmd.cmp_vld   = 1'b0;
        cmd.cmp_idx   = pend_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (func_t'(status.func))
                    FUNC_LOOKUP:
                    begin
                        if (status.n == '0)
                        begin
                            cmd.finish = 1'b1;
                            cmd.res    = RES_MISS;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            // Start the scan at entry zero
                            cmd.rd_en     = 1'b1;
                            cmd.rd_addr   = '0;
                            scan_idx_next = CNT_W'(1);
                            pend_vld_next = 1'b1;
                            pend_idx_next = '0;
                            state_next    = ST_SCAN;
                        end
                    end
                    FUNC_FILL:
                    begin
                        cmd.fill   = (status.n != '0);
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                    FUNC_INVAL:
                    begin
                        cmd.inval  = 1'b1;
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                    default:
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN:
            begin
                cmd.cmp_vld = pend_vld_reg;
                if (status.match)
                begin
                    // Lowest matching index wins: stop on first hit
                    cmd.finish = 1'b1;
                    cmd.res    = RES_HIT;
                    state_next = ST_IDLE;
                end
                else if (!pend_vld_reg || pend_last)
                begin
                    cmd.finish = 1'b1;
                    cmd.res    = RES_MISS;
                    state_next = ST_IDLE;
                end
                else if (scan_idx_reg < status.n)
                begin
                    // Issue the next read while comparing this one
                    cmd.rd_en     = 1'b1;
                    cmd.rd_addr   = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                    pend_vld_next = 1'b1;
                    pend_idx_next = scan_idx_reg[IDX_W-1:0];
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

`ifndef SYNTHESIS
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (state_reg == ST_IDLE))
        else $error("finish not followed by idle");
    a_scan_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> ($past(state_reg) != ST_IDLE))
        else $error("scan entered straight from idle");
    a_fill_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill |-> (status.n != '0))
        else $error("fill issued with cache disabled");
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> busy)
        else $error("read issued while idle");
`endif

endmodule

FILE: sv/mvc_dp.sv
module mvc_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mvc_pkg::cmd_t                       cmd,
    output mvc_pkg::status_t                    status,
    input  logic [mvc_pkg::FUNC_W-1:0]          func,
    input  logic [mvc_pkg::KEY_W-1:0]           key,
    input  logic [mvc_pkg::VAL_W-1:0]           fill_value,
    input  logic                                cfg_we,
    input  logic [mvc_pkg::CFG_W-1:0]           entries_in_use,
    output logic                                done,
    output logic                                hit,
    output logic [mvc_pkg::VAL_W-1:0]           value_out,
    output logic [mvc_pkg::TALLY_W-1:0]         hit_count,
    output logic [mvc_pkg::TALLY_W-1:0]         miss_count
);

    import mvc_pkg::*;

    logic [FUNC_W-1:0]  func_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VAL_W-1:0]   fval_reg;
    logic [CFG_W-1:0]   cfg_reg;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic [TALLY_W-1:0] hits_reg, misses_reg;
    logic               done_reg, hit_reg;
    logic [VAL_W-1:0]   value_reg;

    logic [CMP_W-1:0]   cfg_ext;
    logic [CNT_W-1:0]   n;
    logic [IDX_W-1:0]   fill_idx;
    logic [CNT_W-1:0]   fill_inc;
    logic [LINE_W-1:0]  rd_line;
    logic [KEY_W-1:0]   rd_key;
    logic [VAL_W-1:0]   rd_val;

    // Latch the item on accept
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            key_reg  <= key;
            fval_reg <= fill_value;
        end
    end

    // Clamp the entry count to the store depth
    assign cfg_ext = CMP_W'(cfg_reg);
    assign n = (cfg_ext > CMP_W'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(cfg_ext);

    // Pick the fill slot and the pointer after it
    assign fill_idx = (CNT_W'(ptr_reg) < n) ? ptr_reg : '0;
    assign fill_inc = CNT_W'(fill_idx) + CNT_W'(1);

    always_comb
    begin
        valid_next = valid_reg;
        ptr_next   = ptr_reg;
        if (cfg_we)
        begin
            valid_next = '0;
            ptr_next   = '0;
        end
        else if (cmd.inval)
        begin
            valid_next = '0;
        end
        else if (cmd.fill)
        begin
            valid_next[fill_idx] = 1'b1;
            ptr_next = (fill_inc >= n) ? '0 : fill_inc[IDX_W-1:0];
        end
    end

    // Key and value store
    mvc_ram #(
        .WIDTH (LINE_W),
        .DEPTH (ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (cmd.fill),
        .waddr (fill_idx),
        .wdata ({key_reg, fval_reg}),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_addr),
        .rdata (rd_line)
    );

    assign rd_key = rd_line[LINE_W-1:VAL_W];
    assign rd_val = rd_line[VAL_W-1:0];

    assign status.func  = func_reg;
    assign status.n     = n;
    assign status.match = cmd.cmp_vld && valid_reg[cmd.cmp_idx] && (rd_key == key_reg);

    // Control and tally registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg    <= '0;
            valid_reg  <= '0;
            ptr_reg    <= '0;
            hits_reg   <= '0;
            misses_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg <= entries_in_use;
            end
            valid_reg <= valid_next;
            ptr_reg   <= ptr_next;
            done_reg  <= cmd.finish;
            if (cmd.finish && (cmd.res == RES_HIT) && (hits_reg != '1))
            begin
                hits_reg <= hits_reg + TALLY_W'(1);
            end
            if (cmd.finish && (cmd.res == RES_MISS) && (misses_reg != '1))
            begin
                misses_reg <= misses_reg + TALLY_W'(1);
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            hit_reg   <= (cmd.res == RES_HIT);
            value_reg <= (cmd.res == RES_HIT) ? rd_val : '0;
        end
    end

    assign done       = done_reg;
    assign hit        = hit_reg;
    assign value_out  = value_reg;
    assign hit_count  = hits_reg;
    assign miss_count = misses_reg;

`ifndef SYNTHESIS
    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> ((valid_reg == '0) && (ptr_reg == '0)))
        else $error("config write did not clear the cache");
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(cmd.fill) && !$past(cfg_we)) |-> (CNT_W'(ptr_reg) < $past(n)))
        else $error("replace pointer past entries in use");
    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && (cmd.res != RES_HIT)) |=> $stable(hits_reg))
        else $error("hit count moved without a hit");
    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !hit_reg) |-> (value_reg == '0))
        else $error("value shown without a hit");
`endif

endmodule
